@@ rtl/cvr_pkg.sv @@
// Shared constants, the stage record and the arctangent table for the CORDIC rotator.
// Used by cvr_stage and cordic_vector_rotator_top; depends on nothing else.
package cvr_pkg;

  localparam int unsigned Iterations = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned AngleW     = 10;
  localparam int unsigned CoordW     = 8;
  localparam int unsigned AccW       = 16;
  localparam int unsigned GainW      = 18;
  localparam int unsigned ResAngW    = 10;
  localparam int unsigned FracBits   = 7;

  localparam logic [AngleW-1:0] HalfPiFx  = AngleW'(201);
  localparam logic [AngleW-1:0] PiFx      = AngleW'(402);
  localparam logic [AngleW-1:0] ThreePiFx = AngleW'(603);
  localparam logic [AngleW-1:0] TwoPiFx   = AngleW'(804);
  localparam logic [AngleW-1:0] FivePiFx  = AngleW'(1005);

  localparam logic [1:0] QuadZero  = 2'd0;
  localparam logic [1:0] QuadOne   = 2'd1;
  localparam logic [1:0] QuadTwo   = 2'd2;
  localparam logic [1:0] QuadThree = 2'd3;

  typedef struct packed {
    logic                      vld;
    logic [1:0]                quad;
    logic signed [ResAngW-1:0] ang;
    logic signed [AccW-1:0]    x;
    logic signed [AccW-1:0]    y;
  } cvr_stage_t;

  function automatic logic signed [ResAngW-1:0] cvr_atan(input logic [IdxW-1:0] idx);
    logic signed [ResAngW-1:0] val;
    unique case (idx)
      3'd0:    val = ResAngW'(8'h65);
      3'd1:    val = ResAngW'(8'h3B);
      3'd2:    val = ResAngW'(8'h1F);
      3'd3:    val = ResAngW'(8'h10);
      3'd4:    val = ResAngW'(8'h08);
      3'd5:    val = ResAngW'(8'h04);
      3'd6:    val = ResAngW'(8'h02);
      default: val = ResAngW'(8'h01);
    endcase
    return val;
  endfunction

endpackage

@@ rtl/cvr_stage.sv @@
// One CORDIC micro-rotation stage with its pipeline register.
// Depends on cvr_pkg for the stage record and the arctangent table.
module cvr_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cvr_pkg::IdxW-1:0]  idx_i,
  input  cvr_pkg::cvr_stage_t       stage_i,
  output cvr_pkg::cvr_stage_t       stage_o
);

  logic signed [cvr_pkg::AccW-1:0]    x_in, y_in, dx, dy;
  logic signed [cvr_pkg::ResAngW-1:0] atan_val;
  cvr_pkg::cvr_stage_t                stage_d, stage_q;

  assign x_in     = stage_i.x;
  assign y_in     = stage_i.y;
  assign dx       = x_in >>> idx_i;
  assign dy       = y_in >>> idx_i;
  assign atan_val = cvr_pkg::cvr_atan(idx_i);

  always_comb begin
    stage_d      = stage_i;
    // A residual angle that is not negative turns the point counterclockwise.
    if (!stage_i.ang[cvr_pkg::ResAngW-1]) begin
      stage_d.x   = x_in - dy;
      stage_d.y   = y_in + dx;
      stage_d.ang = stage_i.ang - atan_val;
    end else begin
      stage_d.x   = x_in + dy;
      stage_d.y   = y_in - dx;
      stage_d.ang = stage_i.ang + atan_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

@@ rtl/cordic_vector_rotator_top.sv @@
// Top level of the pipelined CORDIC point rotator: quadrant fold, micro-rotation
// stages, gain correction and back-rotation. Depends on cvr_pkg and cvr_stage.
//
// Usage:
//   A request is taken at every rising edge where start_i is high and busy_o is
//   low. busy_o is always low, so a new request may enter in every cycle.
//   Each request carries angle_i (radians times 128, the low two bits are
//   ignored) and the point x_in_i, y_in_i.
//   The rotated point appears on x_out_o, y_out_o for exactly one cycle,
//   marked by strobe_o, and is taken at the edge that ends that cycle.
//   Path: a request is registered in the quadrant fold, then in one register
//   per micro-rotation stage, then in the gain correction and finally in the
//   output register.
//   Throughput: one request per cycle, set by the one-stage-per-iteration
//   pipeline; results leave in request order.
//   Reset clears all valid bits, so no strobe follows until a new request.
//   The receiver cannot stall; the pipeline never holds.
module cordic_vector_rotator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [cvr_pkg::AngleW-1:0]         angle_i,
  input  logic signed [cvr_pkg::CoordW-1:0]  x_in_i,
  input  logic signed [cvr_pkg::CoordW-1:0]  y_in_i,
  output logic                               strobe_o,
  output logic signed [cvr_pkg::CoordW-1:0]  x_out_o,
  output logic signed [cvr_pkg::CoordW-1:0]  y_out_o
);

  localparam int unsigned Latency = cvr_pkg::Iterations + 3;

  logic                           accept;
  logic [cvr_pkg::AngleW-1:0]     ang_masked, ang_res;
  logic [1:0]                     quad;
  cvr_pkg::cvr_stage_t            fold_d, fold_q;
  cvr_pkg::cvr_stage_t            pipe [0:cvr_pkg::Iterations];

  logic                           gain_vld_q;
  logic [1:0]                     gain_quad_q;
  logic signed [cvr_pkg::CoordW-1:0] gx_d, gy_d, gx_q, gy_q;
  logic signed [cvr_pkg::GainW-1:0]  xw, yw, sum_x, sum_y;

  logic                              strobe_q;
  logic signed [cvr_pkg::CoordW-1:0] rx_d, ry_d, x_out_q, y_out_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Quadrant fold: count whole quarter turns (modulo 4) and keep the residue.
  assign ang_masked = {angle_i[cvr_pkg::AngleW-1:2], 2'b00};

  always_comb begin
    priority if (ang_masked >= cvr_pkg::FivePiFx) begin
      quad    = cvr_pkg::QuadOne;
      ang_res = ang_masked - cvr_pkg::FivePiFx;
    end else if (ang_masked >= cvr_pkg::TwoPiFx) begin
      quad    = cvr_pkg::QuadZero;
      ang_res = ang_masked - cvr_pkg::TwoPiFx;
    end else if (ang_masked >= cvr_pkg::ThreePiFx) begin
      quad    = cvr_pkg::QuadThree;
      ang_res = ang_masked - cvr_pkg::ThreePiFx;
    end else if (ang_masked >= cvr_pkg::PiFx) begin
      quad    = cvr_pkg::QuadTwo;
      ang_res = ang_masked - cvr_pkg::PiFx;
    end else if (ang_masked >= cvr_pkg::HalfPiFx) begin
      quad    = cvr_pkg::QuadOne;
      ang_res = ang_masked - cvr_pkg::HalfPiFx;
    end else begin
      quad    = cvr_pkg::QuadZero;
      ang_res = ang_masked;
    end
  end

  always_comb begin
    fold_d.vld  = accept;
    fold_d.quad = quad;
    fold_d.ang  = $signed(cvr_pkg::ResAngW'(ang_res));
    fold_d.x    = $signed({{(cvr_pkg::AccW - cvr_pkg::CoordW - cvr_pkg::FracBits){x_in_i[7]}},
                           x_in_i, {cvr_pkg::FracBits{1'b0}}});
    fold_d.y    = $signed({{(cvr_pkg::AccW - cvr_pkg::CoordW - cvr_pkg::FracBits){y_in_i[7]}},
                           y_in_i, {cvr_pkg::FracBits{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= '0;
    end else begin
      fold_q <= fold_d;
    end
  end

  assign pipe[0] = fold_q;

  for (genvar g = 0; g < cvr_pkg::Iterations; g++) begin : g_iter
    cvr_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (cvr_pkg::IdxW'(g)),
      .stage_i (pipe[g]),
      .stage_o (pipe[g+1])
    );
  end

  // Gain correction of about 0.6094, formed at full width; only the low output
  // bits survive the final truncation, so bits 14..7 of the sum are kept.
  assign xw    = cvr_pkg::GainW'(pipe[cvr_pkg::Iterations].x);
  assign yw    = cvr_pkg::GainW'(pipe[cvr_pkg::Iterations].y);
  assign sum_x = (xw >>> 6) + (xw >>> 5) + (xw >>> 4) + (xw >>> 1);
  assign sum_y = (yw >>> 6) + (yw >>> 5) + (yw >>> 4) + (yw >>> 1);
  assign gx_d  = sum_x[cvr_pkg::FracBits +: cvr_pkg::CoordW];
  assign gy_d  = sum_y[cvr_pkg::FracBits +: cvr_pkg::CoordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_vld_q <= 1'b0;
    end else begin
      gain_vld_q <= pipe[cvr_pkg::Iterations].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_quad_q <= pipe[cvr_pkg::Iterations].quad;
    gx_q        <= gx_d;
    gy_q        <= gy_d;
  end

  // Rotate back by the counted quarter turns.
  always_comb begin
    unique case (gain_quad_q)
      cvr_pkg::QuadOne: begin
        rx_d = -gy_q;
        ry_d = gx_q;
      end
      cvr_pkg::QuadTwo: begin
        rx_d = -gx_q;
        ry_d = -gy_q;
      end
      cvr_pkg::QuadThree: begin
        rx_d = gy_q;
        ry_d = -gx_q;
      end
      default: begin
        rx_d = gx_q;
        ry_d = gy_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= gain_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_out_q <= rx_d;
    y_out_q <= ry_d;
  end

  assign strobe_o = strobe_q;
  assign x_out_o  = x_out_q;
  assign y_out_o  = y_out_q;

  // Every request yields a result strobe.
  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency strobe_o)
    else $error("request did not produce a result at the expected latency");

  // No result appears without a request at the matching earlier edge.
  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, Latency))
    else $error("result strobe without a matching request");

  // The folded angle always lies inside the first quadrant.
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_q.vld |-> (!fold_q.ang[cvr_pkg::ResAngW-1] &&
                    fold_q.ang <= $signed(cvr_pkg::ResAngW'(200))))
    else $error("folded angle outside the first quadrant");

  // The origin stays at the origin for any angle.
  a_origin_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && x_in_i == '0 && y_in_i == '0) |-> ##Latency
      (x_out_o == '0 && y_out_o == '0))
    else $error("rotation of the origin gave a nonzero point");

endmodule
